// ----- rtl/tppa_pkg.sv -----
`timescale 1ns / 1ps
package tppa_pkg;
  localparam int MaxPeers = 32;
  localparam int IdW = 5;
  localparam int CntW = 6;
  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_ASSIGN = 2'd1;
  localparam logic [1:0] KIND_NOFREE = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_POOL = 2'd1;
  localparam logic [1:0] REG_MARGIN = 2'd2;
  localparam logic [39:0] LoadMax = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] etime;
    logic [5:0] cnt;
    logic [4:0] peer;
    logic [39:0] load;
    logic last;
  } rec_t;
endpackage

// ----- rtl/tppa_ram.sv -----
`timescale 1ns / 1ps
module tppa_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/timed_peer_pool_allocator_unit.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Contents
// in      | in  | tdata: start_time[31:0], hold_duration[55:32], random_value[71:56]
//         |     | tuser: req_type
// out     | out | tdata: event_time, busy_count, peer_id, peer_load
//         |     | tuser: record_kind; tlast: last
// cfg     | in  | write enable, register index, 24-bit data
// Each scan pass reads the peer memories one entry per cycle unless stalled. An
// arrival takes one scan per release plus a final release scan, a free-peer scan
// (min-load in load mode), a pick scan and a write, or ends after the free-peer
// scan if none is free. A flush: a scan per release plus one. Reset is synchronous
// and needs no clearing pass; load memory is cleared lazily by a valid bit per peer.
// The engine stalls while a record waits in the output register.
module timed_peer_pool_allocator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // start_time, hold_duration, random_value
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // event_time, busy_count, peer_id, peer_load
  output logic [1:0]   out_tuser,  // record_kind
  output logic         out_tlast,  // last
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import tppa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RSCAN = 3'd1;
  localparam logic [2:0] S_MSCAN = 3'd2;
  localparam logic [2:0] S_PSCAN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] st_r;
  logic mode_r;
  logic [5:0] pool_r;
  logic [23:0] margin_r;
  logic flush_r;
  logic [31:0] start_r;
  logic [23:0] hold_r;
  logic [15:0] rnd_r;
  logic [MaxPeers-1:0] busy_r, lval_r;
  logic [5:0] total_r;
  logic [15:0] stamp_r;
  logic [5:0] idx_r;
  logic rd_v_r;
  logic [4:0] rd_i_r;
  logic best_v_r;
  logic [4:0] best_r;
  logic [31:0] best_t_r;
  logic [15:0] best_age_r;
  logic [39:0] min_r;
  logic [5:0] cnt_r, seen_r;
  logic [5:0] pick_r;
  logic found_r;
  logic [4:0] peer_r;
  logic [39:0] peer_load_r;
  logic ov_r;
  rec_t rec_r;

  logic [31:0] et_q;
  logic [15:0] as_q;
  logic [39:0] ld_q;
  logic et_we, ld_we;
  logic [4:0] w_i;
  logic [31:0] et_wd;
  logic [39:0] ld_wd;
  logic [4:0] r_i;

  tppa_ram #(.Width(32), .Depth(MaxPeers)) u_et (
    .clk, .we(et_we), .waddr(w_i), .wdata(et_wd), .raddr(r_i), .rdata(et_q));
  tppa_ram #(.Width(16), .Depth(MaxPeers)) u_as (
    .clk, .we(et_we), .waddr(w_i), .wdata(stamp_r), .raddr(r_i), .rdata(as_q));
  tppa_ram #(.Width(40), .Depth(MaxPeers)) u_ld (
    .clk, .we(ld_we), .waddr(w_i), .wdata(ld_wd), .raddr(r_i), .rdata(ld_q));

  logic [5:0] usable;
  logic [39:0] ldv;
  logic [15:0] age;
  logic [24:0] occ;
  logic [32:0] fin;
  logic [40:0] ldsum;
  logic [21:0] prod;
  logic scan_end;

  assign usable = (pool_r > 6'(MaxPeers)) ? 6'(MaxPeers) : pool_r;
  assign ldv = lval_r[rd_i_r] ? ld_q : '0;
  assign age = stamp_r - as_q;
  assign occ = {1'b0, hold_r} + {1'b0, margin_r};
  assign fin = {1'b0, start_r} + 33'(occ);
  assign ldsum = {1'b0, peer_load_r} + 41'(occ);
  assign prod = rnd_r * cnt_r;
  assign r_i = idx_r[4:0];
  assign scan_end = !rd_v_r && (idx_r == 6'(MaxPeers));
  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = {5'd0, rec_r.load, rec_r.peer, rec_r.cnt, rec_r.etime};
  assign out_tuser = rec_r.kind;
  assign out_tlast = rec_r.last;

  always_comb begin
    et_we = 1'b0;
    ld_we = 1'b0;
    w_i = peer_r;
    et_wd = fin[32] ? 32'hFFFF_FFFF : fin[31:0];
    ld_wd = ldsum[40] ? LoadMax : ldsum[39:0];
    if (st_r == S_EMIT && !ov_r) begin
      et_we = 1'b1;
      ld_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      mode_r <= 1'b0;
      pool_r <= 6'd32;
      margin_r <= '0;
      busy_r <= '0;
      lval_r <= '0;
      total_r <= '0;
      stamp_r <= '0;
      ov_r <= 1'b0;
      idx_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: mode_r <= cfg_data[0];
          REG_POOL: pool_r <= cfg_data[5:0];
          REG_MARGIN: margin_r <= cfg_data;
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            flush_r <= in_tuser;
            start_r <= in_tdata[31:0];
            hold_r <= in_tdata[55:32];
            rnd_r <= in_tdata[71:56];
            st_r <= S_RSCAN;
            idx_r <= '0;
            rd_v_r <= 1'b0;
            best_v_r <= 1'b0;
          end
        end
        S_RSCAN: begin
          if (!ov_r) begin
            if (idx_r != 6'(MaxPeers)) idx_r <= idx_r + 6'd1;
            rd_v_r <= (idx_r != 6'(MaxPeers));
            rd_i_r <= r_i;
            if (rd_v_r && busy_r[rd_i_r] && (flush_r || et_q <= start_r)) begin
              if (!best_v_r || et_q < best_t_r ||
                  (et_q == best_t_r && age > best_age_r)) begin
                best_v_r <= 1'b1;
                best_r <= rd_i_r;
                best_t_r <= et_q;
                best_age_r <= age;
                peer_load_r <= ldv;
              end
            end
            if (scan_end) begin
              idx_r <= '0;
              best_v_r <= 1'b0;
              if (best_v_r) begin
                busy_r[best_r] <= 1'b0;
                total_r <= total_r - ((total_r != 0) ? 6'd1 : 6'd0);
                rec_r <= '{KIND_RELEASE, best_t_r,
                           total_r - ((total_r != 0) ? 6'd1 : 6'd0), best_r,
                           peer_load_r, 1'b0};
                ov_r <= 1'b1;
              end else if (flush_r) begin
                total_r <= '0;
                rec_r <= '{KIND_FLUSH, 32'd0, 6'd0, 5'd0, 40'd0, 1'b1};
                ov_r <= 1'b1;
                st_r <= S_IDLE;
              end else begin
                cnt_r <= '0;
                min_r <= LoadMax;
                st_r <= S_MSCAN;
              end
            end
          end
        end
        S_MSCAN: begin
          if (idx_r != 6'(MaxPeers)) idx_r <= idx_r + 6'd1;
          rd_v_r <= (idx_r != 6'(MaxPeers));
          rd_i_r <= r_i;
          if (rd_v_r && !busy_r[rd_i_r] && {1'b0, rd_i_r} < usable) begin
            if (!mode_r) cnt_r <= cnt_r + 6'd1;
            else if (cnt_r == 0 || ldv < min_r) begin
              min_r <= ldv;
              cnt_r <= 6'd1;
            end else if (ldv == min_r) cnt_r <= cnt_r + 6'd1;
          end
          if (scan_end) begin
            idx_r <= '0;
            if (cnt_r == 0) begin
              if (!ov_r) begin
                rec_r <= '{KIND_NOFREE, start_r, total_r, 5'd0, 40'd0, 1'b1};
                ov_r <= 1'b1;
                st_r <= S_IDLE;
              end else begin
                idx_r <= idx_r;
              end
            end else begin
              pick_r <= 6'(prod[21:16]);
              seen_r <= '0;
              found_r <= 1'b0;
              st_r <= S_PSCAN;
            end
          end
        end
        S_PSCAN: begin
          if (idx_r != 6'(MaxPeers)) idx_r <= idx_r + 6'd1;
          rd_v_r <= (idx_r != 6'(MaxPeers));
          rd_i_r <= r_i;
          if (rd_v_r && !found_r && !busy_r[rd_i_r] && {1'b0, rd_i_r} < usable &&
              (!mode_r || ldv == min_r)) begin
            if (seen_r == pick_r) begin
              found_r <= 1'b1;
              peer_r <= rd_i_r;
              peer_load_r <= ldv;
            end
            seen_r <= seen_r + 6'd1;
          end
          if (scan_end) st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!ov_r) begin
            busy_r[peer_r] <= 1'b1;
            lval_r[peer_r] <= 1'b1;
            stamp_r <= stamp_r + 16'd1;
            total_r <= total_r + 6'd1;
            rec_r <= '{KIND_ASSIGN, start_r, total_r + 6'd1, peer_r, ld_wd, 1'b1};
            ov_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= 6'(MaxPeers)) else $error("busy count overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(rec_r)) else $error("record lost");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !rd_v_r || st_r == S_IDLE) else $error("scan outside item");
endmodule
